[sv/assert_macros.svh]
// Assertion helpers; every user module has clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising clk edge, off while in reset.
`define ASSERT_AT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true at a clk edge.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_AT_CLK(label, !(cond), msg)

`endif

[sv/lmc_pkg.sv]
package lmc_pkg;

	localparam int MAX_COLS     = 1024;
	localparam int PIXEL_BITS   = 16;
	localparam int COL_BITS     = $clog2(MAX_COLS);
	localparam int COL_CNT_BITS = COL_BITS + 1;

	localparam int ROW_BITS     = 12;
	localparam int ROW_CNT_BITS = 13;
	localparam int ROW_LIMIT    = 4096;
	localparam int COLCFG_BITS  = 11;

	localparam int COUNT_BITS   = 22;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam int RES_DEPTH    = 4;
	localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
	localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

	// configuration register indexes
	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef logic [8:0][PIXEL_BITS-1:0] win_t;  // index = row * 3 + col, col 2 newest
	typedef logic signed [1:0] step_t;

	localparam step_t ROW_STEP [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1};
	localparam step_t COL_STEP [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1};

	// position flags of one element travelling down the pipe
	typedef struct packed {
		logic valid;
		logic r_ge1;
		logic r_ge2;
		logic c_ge1;
		logic c_ge2;
		logic last_col;
		logic last_row;
	} pos_t;

	// centre (wr, wc) strictly above each of its enabled neighbours
	function automatic logic is_peak(input win_t w, input int wr, input int wc,
		input logic up, input logic down, input logic left, input logic right);
		logic pk;
		int   dr;
		int   dc;
		int   idx;
		pk = 1'b1;
		for (int k = 0; k < 8; k++) begin
			dr  = int'(ROW_STEP[k]);
			dc  = int'(COL_STEP[k]);
			idx = (wr + dr) * 3 + wc + dc;
			if (!((dr < 0 && !up) || (dr > 0 && !down) || (dc < 0 && !left) ||
				(dc > 0 && !right)) && idx >= 0 && idx <= 8) begin
				if ($signed(w[4'(idx)]) >= $signed(w[4'(wr * 3 + wc)]))
					pk = 1'b0;
			end
		end
		return pk;
	endfunction

endpackage

[sv/lmc_line_store.sv]
`include "assert_macros.svh"

module lmc_line_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [lmc_pkg::COL_BITS-1:0] rd_addr,
	input  lmc_pkg::pix_t              key,
	output lmc_pkg::pix_t              above_s1,
	output lmc_pkg::pix_t              middle_s1,
	output lmc_pkg::pix_t              key_s1
);
	import lmc_pkg::*;

	pix_t upper_mem  [MAX_COLS];
	pix_t middle_mem [MAX_COLS];

	pix_t                upper_rd_q;
	pix_t                middle_rd_q;
	pix_t                fwd_upper_q;
	pix_t                fwd_middle_q;
	logic                fwd_q;
	logic                valid_s1_q;
	logic [COL_BITS-1:0] addr_s1_q;
	pix_t                key_s1_q;

	// same column read right after its write (one-column frames): take the write data
	assign above_s1  = fwd_q ? fwd_upper_q  : upper_rd_q;
	assign middle_s1 = fwd_q ? fwd_middle_q : middle_rd_q;
	assign key_s1    = key_s1_q;

	always_ff @(posedge clk) begin
		if (valid_s1_q) begin
			upper_mem[addr_s1_q]  <= middle_s1;
			middle_mem[addr_s1_q] <= key_s1_q;
		end
		if (rd_en) begin
			upper_rd_q  <= upper_mem[rd_addr];
			middle_rd_q <= middle_mem[rd_addr];
			addr_s1_q   <= rd_addr;
			key_s1_q    <= key;
		end
		fwd_upper_q  <= middle_s1;
		fwd_middle_q <= key_s1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			fwd_q      <= 1'b0;
		end else begin
			valid_s1_q <= rd_en;
			fwd_q      <= rd_en && valid_s1_q && (addr_s1_q == rd_addr);
		end
	end

	`ASSERT_AT_CLK(a_fwd_same_col, fwd_q |-> $past(valid_s1_q) && addr_s1_q == $past(addr_s1_q), "forward without matching write")

endmodule

[sv/lmc_peak_eval.sv]
module lmc_peak_eval (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lmc_pkg::pos_t                 pos_s1,
	input  lmc_pkg::pix_t                 above_s1,
	input  lmc_pkg::pix_t                 middle_s1,
	input  lmc_pkg::pix_t                 key_s1,
	output logic                          end_s2,
	output logic                          push,
	output logic [lmc_pkg::COUNT_BITS-1:0] push_count
);
	import lmc_pkg::*;

	win_t                  win_q;
	pos_t                  pos_s2;
	logic [COUNT_BITS-1:0] count_q;
	logic [3:0]            hit;
	logic [2:0]            hits;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] next_count;

	always_comb begin
		hit[0] = pos_s2.r_ge1 && pos_s2.c_ge1 &&
			is_peak(win_q, 1, 1, pos_s2.r_ge2, 1'b1, pos_s2.c_ge2, 1'b1);
		hit[1] = pos_s2.r_ge1 && pos_s2.last_col &&
			is_peak(win_q, 1, 2, pos_s2.r_ge2, 1'b1, pos_s2.c_ge1, 1'b0);
		hit[2] = pos_s2.last_row && pos_s2.c_ge1 &&
			is_peak(win_q, 2, 1, pos_s2.r_ge1, 1'b0, pos_s2.c_ge2, 1'b1);
		hit[3] = pos_s2.last_row && pos_s2.last_col &&
			is_peak(win_q, 2, 2, pos_s2.r_ge1, 1'b0, pos_s2.c_ge1, 1'b0);
		hits = 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]);
		sum  = {1'b0, count_q} + (COUNT_BITS + 1)'(hits);
		next_count = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_BITS-1:0];
	end

	assign end_s2     = pos_s2.valid && pos_s2.last_col && pos_s2.last_row;
	assign push       = end_s2;
	assign push_count = next_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			pos_s2  <= '0;
			count_q <= '0;
		end else begin
			pos_s2 <= pos_s1;
			if (pos_s1.valid) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= above_s1;
				win_q[3] <= win_q[4];
				win_q[4] <= win_q[5];
				win_q[5] <= middle_s1;
				win_q[6] <= win_q[7];
				win_q[7] <= win_q[8];
				win_q[8] <= key_s1;
			end
			if (pos_s2.valid)
				count_q <= end_s2 ? '0 : next_count;
		end
	end

endmodule

[sv/lmc_result_fifo.sv]
`include "assert_macros.svh"

module lmc_result_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [lmc_pkg::COUNT_BITS-1:0]  push_count,
	output logic [lmc_pkg::RES_CNT_BITS-1:0] level,
	output logic                            tvalid,
	input  logic                            tready,
	output logic [lmc_pkg::COUNT_BITS-1:0]  tdata
);
	import lmc_pkg::*;

	logic [COUNT_BITS-1:0]   buf_q [RES_DEPTH];
	logic [RES_PTR_BITS-1:0] wr_ptr_q;
	logic [RES_PTR_BITS-1:0] rd_ptr_q;
	logic [RES_CNT_BITS-1:0] cnt_q;
	logic                    pop;

	assign tvalid = (cnt_q != '0);
	assign tdata  = buf_q[rd_ptr_q];
	assign pop    = tvalid && tready;
	assign level  = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= push_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + RES_PTR_BITS'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + RES_PTR_BITS'(1);
			cnt_q <= cnt_q + RES_CNT_BITS'(push) - RES_CNT_BITS'(pop);
		end
	end

	`ASSERT_NEVER(a_fifo_overflow, push && !pop && cnt_q == RES_CNT_BITS'(RES_DEPTH), "result fifo overflow")
	`ASSERT_AT_CLK(a_fifo_level, 1'b1 |=> cnt_q == RES_CNT_BITS'($past(cnt_q) + $past(push) - $past(pop)), "result fifo level mismatch")

endmodule

[sv/local_maximum_counter.sv]
// The frame count passes stage 1, stage 2 and the result fifo before it is offered on m_axis.
// Throughput: one element per cycle but for the wait below; line stores are synchronous RAMs,
// read at accept, written back next cycle, with forwarding for back-to-back hits on one column.
// A frame's last element waits only while 4 counts are queued or in flight (4-entry result fifo).
// Reset (arst_n low, async): counters, window, count and fifo clear; size registers go to 1x1.
// Line stores are not cleared and need no clearing pass; unread rows are masked by position.
`include "assert_macros.svh"

module local_maximum_counter (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	// pixel stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] pixel (signed)
	// count stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [21:0] maxima_count, [23:22] zero
);
	import lmc_pkg::*;

	// config registers
	logic [ROW_CNT_BITS-1:0] rows_q;
	logic [COLCFG_BITS-1:0]  cols_q;

	// raster position of the next element
	logic [COL_BITS-1:0]     col_q;
	logic [ROW_BITS-1:0]     row_q;

	logic [ROW_CNT_BITS-1:0] rows_eff;
	logic [COL_CNT_BITS-1:0] cols_eff;
	logic                    last_col;
	logic                    last_row;
	logic                    end_s0;
	logic                    accept;
	pos_t                    pos_s1;
	pos_t                    pos_s0;

	pix_t                    above_s1;
	pix_t                    middle_s1;
	pix_t                    key_s1;

	logic                    end_s1;
	logic                    end_s2;
	logic                    push;
	logic [COUNT_BITS-1:0]   push_count;
	logic [RES_CNT_BITS-1:0] level;
	logic [RES_CNT_BITS:0]   pending;
	logic [COUNT_BITS-1:0]   res_data;

	// size clamps: zero acts as one, oversize acts as the limit
	always_comb begin
		priority if (rows_q == '0)
			rows_eff = ROW_CNT_BITS'(1);
		else if (32'(rows_q) > ROW_LIMIT)
			rows_eff = ROW_CNT_BITS'(ROW_LIMIT);
		else
			rows_eff = rows_q;

		priority if (cols_q == '0)
			cols_eff = COL_CNT_BITS'(1);
		else if (32'(cols_q) > MAX_COLS)
			cols_eff = COL_CNT_BITS'(MAX_COLS);
		else
			cols_eff = COL_CNT_BITS'(cols_q);
	end

	assign last_col = ({1'b0, col_q} + COL_CNT_BITS'(1)) >= cols_eff;
	assign last_row = ({1'b0, row_q} + ROW_CNT_BITS'(1)) >= rows_eff;
	assign end_s0   = last_col && last_row;

	// frame ends in flight plus queued counts never exceed the fifo depth
	assign end_s1   = pos_s1.valid && pos_s1.last_col && pos_s1.last_row;
	assign pending  = (RES_CNT_BITS + 1)'(level) + (RES_CNT_BITS + 1)'(end_s1) +
		(RES_CNT_BITS + 1)'(end_s2);

	assign s_axis_tready = !end_s0 || (pending < (RES_CNT_BITS + 1)'(RES_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		pos_s0.valid    = accept;
		pos_s0.r_ge1    = (row_q != '0);
		pos_s0.r_ge2    = (row_q >= ROW_BITS'(2));
		pos_s0.c_ge1    = (col_q != '0);
		pos_s0.c_ge2    = (col_q >= COL_BITS'(2));
		pos_s0.last_col = last_col;
		pos_s0.last_row = last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROW_CNT_BITS'(1);
			cols_q <= COLCFG_BITS'(1);
			col_q  <= '0;
			row_q  <= '0;
			pos_s1 <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROW_COUNT:    rows_q <= cfg_data;
					REG_COLUMN_COUNT: cols_q <= cfg_data[COLCFG_BITS-1:0];
					default: ;
				endcase
			end
			pos_s1 <= pos_s0;
			if (accept) begin
				if (!last_col) begin
					col_q <= col_q + COL_BITS'(1);
				end else begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_BITS'(1);
				end
			end
		end
	end

	// upper / middle line RAMs, read at accept, written back in stage 1
	lmc_line_store u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr   (col_q),
		.key       (s_axis_tdata),
		.above_s1  (above_s1),
		.middle_s1 (middle_s1),
		.key_s1    (key_s1)
	);

	// 3x3 window, four centre decisions, saturating count
	lmc_peak_eval u_peak_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.pos_s1     (pos_s1),
		.above_s1   (above_s1),
		.middle_s1  (middle_s1),
		.key_s1     (key_s1),
		.end_s2     (end_s2),
		.push       (push),
		.push_count (push_count)
	);

	lmc_result_fifo u_result_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_count (push_count),
		.level      (level),
		.tvalid     (m_axis_tvalid),
		.tready     (m_axis_tready),
		.tdata      (res_data)
	);

	assign m_axis_tdata = {2'b00, res_data};

	`ASSERT_NEVER(a_credit_bound, pending > (RES_CNT_BITS + 1)'(RES_DEPTH), "result credit exceeded")

endmodule
